// ===== rtl/core/xml_char_tokenizer_core_assert.svh =====
// Assertion macros for the XML character tokenizer core.
// Used by modules under rtl/core; the bodies are empty in synthesis builds.
`ifndef XML_CHAR_TOKENIZER_CORE_ASSERT_SVH
`define XML_CHAR_TOKENIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define XCT_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("xct assertion failed: same-cycle implication");
`define XCT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("xct assertion failed: next-cycle implication");
`else
`define XCT_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define XCT_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== rtl/core/xct_pkg.sv =====
// Shared types and constants for the XML character tokenizer core.
// No dependencies; used by xct_step and xml_char_tokenizer_core.
`timescale 1ns / 1ps
`default_nettype none

package xct_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int LVL_W     = $clog2(MAX_DEPTH);
    localparam int DEPTH_W   = 5;
    localparam int TDATA_W   = 24;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [3:0] {
        ST_LABEL  = 4'd0,
        ST_NAME   = 4'd1,
        ST_ANAME  = 4'd2,
        ST_AVALUE = 4'd3,
        ST_STRING = 4'd4,
        ST_AWAIT  = 4'd5,
        ST_EQUAL  = 4'd6,
        ST_BODY   = 4'd7,
        ST_EXIT   = 4'd9,
        ST_IGNORE = 4'd10
    } parse_state_t;

    typedef enum logic [2:0] {
        KIND_NONE       = 3'd0,
        KIND_ELEM       = 3'd1,
        KIND_ATTR_NAME  = 3'd2,
        KIND_ATTR_VALUE = 3'd3,
        KIND_TEXT       = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STAT_RUNNING   = 2'd0,
        STAT_PAST_ROOT = 2'd1,
        STAT_OVERFLOW  = 2'd2,
        STAT_ZERO_END  = 2'd3
    } status_t;

    typedef struct packed {
        parse_state_t     state;
        logic [LVL_W-1:0] level;
        logic             skip;
        status_t          done;
    } tok_state_t;

    typedef struct packed {
        kind_t              kind;
        logic               char_valid;
        logic [7:0]         out_char;
        logic               rec_end;
        logic               level_open;
        logic               level_close;
        logic [DEPTH_W-1:0] depth;
        status_t            status;
    } result_t;

    localparam tok_state_t TOK_RESET = '{
        state: ST_BODY,
        level: '0,
        skip:  1'b1,
        done:  STAT_RUNNING
    };

endpackage

`default_nettype wire

// ===== rtl/core/xct_step.sv =====
// Per-byte transition logic of the XML tokenizer: table lookup, depth
// check and record output. Pure combinational; depends on xct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xct_step (
    input  wire logic [7:0]         in_byte,
    input  wire logic               start_of_doc,
    input  wire xct_pkg::tok_state_t cur_state,
    output xct_pkg::tok_state_t      nxt_state,
    output xct_pkg::result_t         result
);

    typedef enum logic [1:0] {
        DIR_KEEP,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    xct_pkg::tok_state_t   cur;
    xct_pkg::parse_state_t to;
    dir_t                  dir;
    logic                  hit;
    logic                  cross_rec;
    logic                  slack;
    logic                  slack_eff;
    logic                  sep;
    logic                  cur_rec;
    logic                  to_rec;
    logic                  ovf;
    logic                  unf;
    logic [xct_pkg::LVL_W+xct_pkg::DEPTH_W-1:0] depth_wide;

    function automatic logic is_rec(input xct_pkg::parse_state_t s);
        return (s == xct_pkg::ST_NAME) || (s == xct_pkg::ST_ANAME) ||
               (s == xct_pkg::ST_AVALUE) || (s == xct_pkg::ST_STRING);
    endfunction

    function automatic xct_pkg::kind_t kind_of(input xct_pkg::parse_state_t s);
        xct_pkg::kind_t k;
        unique case (s)
            xct_pkg::ST_NAME:   k = xct_pkg::KIND_ELEM;
            xct_pkg::ST_ANAME:  k = xct_pkg::KIND_ATTR_NAME;
            xct_pkg::ST_AVALUE: k = xct_pkg::KIND_ATTR_VALUE;
            xct_pkg::ST_STRING: k = xct_pkg::KIND_TEXT;
            default:            k = xct_pkg::KIND_NONE;
        endcase
        return k;
    endfunction

    assign cur = start_of_doc ? xct_pkg::TOK_RESET : cur_state;
    assign sep = (in_byte <= xct_pkg::CH_SPACE) || (in_byte >= xct_pkg::CH_DEL);

    // transition table: exact code first, then separator/wildcard entry
    always_comb
    begin
        hit       = 1'b1;
        to        = cur.state;
        dir       = DIR_KEEP;
        cross_rec = 1'b0;
        slack     = 1'b1;
        unique case (cur.state)
            xct_pkg::ST_BODY:
            begin
                if (in_byte == xct_pkg::CH_LT) begin
                    to = xct_pkg::ST_LABEL;
                end else begin
                    to = xct_pkg::ST_STRING; dir = DIR_UP; cross_rec = 1'b1; slack = 1'b0;
                end
            end
            xct_pkg::ST_LABEL:
            begin
                if (in_byte == xct_pkg::CH_SLASH) begin
                    to = xct_pkg::ST_EXIT;
                end else if (in_byte == xct_pkg::CH_BANG || in_byte == xct_pkg::CH_QMARK) begin
                    to = xct_pkg::ST_IGNORE;
                end else begin
                    to = xct_pkg::ST_NAME; dir = DIR_UP; cross_rec = 1'b1; slack = 1'b0;
                end
            end
            xct_pkg::ST_AWAIT:
            begin
                if (in_byte == xct_pkg::CH_SLASH) begin
                    to = xct_pkg::ST_EXIT;
                end else if (in_byte == xct_pkg::CH_GT) begin
                    to = xct_pkg::ST_BODY;
                end else begin
                    to = xct_pkg::ST_ANAME; dir = DIR_UP; cross_rec = 1'b1;
                end
            end
            xct_pkg::ST_EXIT:
            begin
                if (in_byte == xct_pkg::CH_GT) begin
                    to = xct_pkg::ST_BODY; dir = DIR_DOWN;
                end else begin
                    hit = 1'b0;
                end
            end
            xct_pkg::ST_IGNORE:
            begin
                if (in_byte == xct_pkg::CH_GT) to = xct_pkg::ST_BODY;
                else hit = 1'b0;
            end
            xct_pkg::ST_ANAME:
            begin
                if (in_byte == xct_pkg::CH_EQ) to = xct_pkg::ST_EQUAL;
                else hit = 1'b0;
            end
            xct_pkg::ST_EQUAL:
            begin
                if (in_byte == xct_pkg::CH_QUOTE) begin
                    to = xct_pkg::ST_AVALUE; slack = 1'b0;
                end else begin
                    hit = 1'b0;
                end
            end
            xct_pkg::ST_AVALUE:
            begin
                if (in_byte == xct_pkg::CH_QUOTE) begin
                    to = xct_pkg::ST_AWAIT; dir = DIR_DOWN;
                end else begin
                    hit = 1'b0;
                end
            end
            xct_pkg::ST_NAME:
            begin
                if (in_byte == xct_pkg::CH_GT) to = xct_pkg::ST_BODY;
                else if (sep) to = xct_pkg::ST_AWAIT;
                else hit = 1'b0;
            end
            xct_pkg::ST_STRING:
            begin
                if (in_byte == xct_pkg::CH_LT) begin
                    to = xct_pkg::ST_LABEL; dir = DIR_DOWN; slack = 1'b0;
                end else if (sep) begin
                    to = xct_pkg::ST_BODY; dir = DIR_DOWN;
                end else begin
                    hit = 1'b0;
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign slack_eff = hit ? slack : cur.skip;
    assign cur_rec   = is_rec(cur.state);
    assign to_rec    = is_rec(to);
    assign ovf = (dir == DIR_UP) && (cur.level == xct_pkg::LVL_W'(xct_pkg::MAX_DEPTH - 1));
    assign unf = (dir == DIR_DOWN) && (cur.level == '0);

    always_comb
    begin
        nxt_state = cur;
        result    = '0;
        if (cur.done == xct_pkg::STAT_RUNNING) begin
            if (in_byte == xct_pkg::CH_NUL) begin
                nxt_state.done = xct_pkg::STAT_ZERO_END;
            end else if (!(cur.skip && sep)) begin
                if (ovf) begin
                    nxt_state.done = xct_pkg::STAT_OVERFLOW;
                end else if (unf) begin
                    nxt_state.done = xct_pkg::STAT_PAST_ROOT;
                end else begin
                    result.level_open  = (dir == DIR_UP);
                    result.level_close = (dir == DIR_DOWN);
                    if (cur_rec && !to_rec) begin
                        result.kind    = kind_of(cur.state);
                        result.rec_end = 1'b1;
                    end else if (cross_rec || cur_rec) begin
                        result.kind       = cross_rec ? kind_of(to) : kind_of(cur.state);
                        result.char_valid = 1'b1;
                        result.out_char   = in_byte;
                    end
                    unique case (dir)
                        DIR_UP:   nxt_state.level = cur.level + xct_pkg::LVL_W'(1);
                        DIR_DOWN: nxt_state.level = cur.level - xct_pkg::LVL_W'(1);
                        default:  nxt_state.level = cur.level;
                    endcase
                    nxt_state.state = to;
                    nxt_state.skip  = slack_eff;
                end
            end
        end
        depth_wide    = {{xct_pkg::DEPTH_W{1'b0}}, nxt_state.level};
        result.depth  = depth_wide[xct_pkg::DEPTH_W-1:0];
        result.status = nxt_state.done;
    end

endmodule

`default_nettype wire

// ===== rtl/core/xml_char_tokenizer_core.sv =====
// Pipeline: an input beat goes through the input register, then the result
//   register, to its output beat. Throughput: one byte per cycle while m_tready
//   does not stall, set by the single pass through the transition table between the two registers.
// Reset (rst_n low, async): pipeline empty, parse state body, depth zero,
//   blank skipping on, status running. A beat with tuser set restarts the doc.
`timescale 1ns / 1ps
`default_nettype none
`include "xml_char_tokenizer_core_assert.svh"

// Top level: input stage, xct_step, result stage. Depends on xct_pkg.
module xml_char_tokenizer_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,  // [7:0] in_byte
    input  wire logic                        s_tuser,  // [0] start_of_doc
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [0] char_valid, [8:1] out_char, [9] level_open, [10] level_close,
    // [15:11] nest_depth, [17:16] parse_status, [23:18] zero
    output logic [xct_pkg::TDATA_W-1:0]      m_tdata,
    output logic [2:0]                       m_tuser,  // [2:0] record_kind
    output logic                             m_tlast   // record_end
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                in_start_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    xct_pkg::result_t    out_reg;
    xct_pkg::result_t    step_result;
    xct_pkg::tok_state_t tok_reg;
    xct_pkg::tok_state_t tok_next;
    logic                advance;
    logic                in_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    xct_step u_step (
        .in_byte      (in_byte_reg),
        .start_of_doc (in_start_reg),
        .cur_state    (tok_reg),
        .nxt_state    (tok_next),
        .result       (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire) in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tok_reg       <= xct_pkg::TOK_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance) out_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.rec_end;
    assign m_tdata  = {6'b0, out_reg.status, out_reg.depth, out_reg.level_close,
                       out_reg.level_open, out_reg.out_char, out_reg.char_valid};

    // a beat carries a char or an end marker, never both
    `XCT_ASSERT_IMPLY(a_char_or_end, clk, rst_n, m_tvalid, !(out_reg.char_valid && out_reg.rec_end))
    `XCT_ASSERT_IMPLY(a_char_has_kind, clk, rst_n, m_tvalid && (out_reg.char_valid || out_reg.rec_end), out_reg.kind != xct_pkg::KIND_NONE)
    `XCT_ASSERT_IMPLY(a_open_close, clk, rst_n, m_tvalid, !(out_reg.level_open && out_reg.level_close))
    // once finished, the parser holds until a new document starts
    `XCT_ASSERT_NEXT(a_done_hold, clk, rst_n, advance && !in_start_reg && tok_reg.done != xct_pkg::STAT_RUNNING, $stable(tok_reg))

endmodule

`default_nettype wire

// ===== bench/tb_xml_char_tokenizer_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for xml_char_tokenizer_core: byte documents in, one token beat out.
// Depends on xct_pkg and the core RTL; predicts each beat with an in-bench tokenizer model.

module tb_xml_char_tokenizer_core;
    import xct_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DOC_TARGET  = 1080;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [7:0] ch;
        logic       sod;
        logic       drain;
    } doc_byte_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    doc_byte_t doc_bytes[$];
    result_t   expected_tokens[$];
    result_t   token_want;
    bit        start_next = 1'b0;
    bit        drain_next = 1'b0;
    int        mismatches = 0;
    int        tokens_seen = 0;
    int        cycles = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        hold_left = 0;
    int        holds_done = 0;
    int        rx_tick = 0;
    int        rx_mode = 0;

    // tokenizer state mirrored by the predictor
    parse_state_t tk_state = ST_BODY;
    int           tk_level = 0;
    logic         tk_skip  = 1'b1;
    status_t      tk_done  = STAT_RUNNING;

    xml_char_tokenizer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_sep(input logic [7:0] b);
        return (b <= CH_SPACE) || (b >= CH_DEL);
    endfunction

    function automatic bit is_rec(input parse_state_t s);
        return (s >= ST_NAME) && (s <= ST_STRING);
    endfunction

    function automatic result_t tokenize_byte(input logic [7:0] b, input logic sod);
        result_t      r;
        parse_state_t nxt;
        int           delta;
        int           nd;
        logic         cross_rec;
        logic         slack;
        logic         hit;
        if (sod)
        begin
            tk_state = ST_BODY;
            tk_level = 0;
            tk_skip  = 1'b1;
            tk_done  = STAT_RUNNING;
        end
        r = '0;
        if (tk_done == STAT_RUNNING)
        begin
            if (b == CH_NUL)
                tk_done = STAT_ZERO_END;
            else if (!(tk_skip && is_sep(b)))
            begin
                hit       = 1'b1;
                nxt       = tk_state;
                delta     = 0;
                cross_rec = 1'b0;
                slack     = 1'b1;
                case (tk_state)
                    ST_BODY:
                        if (b != CH_LT)
                        begin
                            nxt = ST_STRING; delta = 1; cross_rec = 1'b1; slack = 1'b0;
                        end
                        else
                            nxt = ST_LABEL;
                    ST_LABEL:
                        if (b == CH_SLASH)
                            nxt = ST_EXIT;
                        else if (b == CH_BANG || b == CH_QMARK)
                            nxt = ST_IGNORE;
                        else
                        begin
                            nxt = ST_NAME; delta = 1; cross_rec = 1'b1; slack = 1'b0;
                        end
                    ST_AWAIT:
                        if (b == CH_SLASH)
                            nxt = ST_EXIT;
                        else if (b == CH_GT)
                            nxt = ST_BODY;
                        else
                        begin
                            nxt = ST_ANAME; delta = 1; cross_rec = 1'b1;
                        end
                    ST_EXIT:
                        if (b == CH_GT)
                        begin
                            nxt = ST_BODY; delta = -1;
                        end
                        else
                            hit = 1'b0;
                    ST_IGNORE:
                        if (b == CH_GT)
                            nxt = ST_BODY;
                        else
                            hit = 1'b0;
                    ST_ANAME:
                        if (b == CH_EQ)
                            nxt = ST_EQUAL;
                        else
                            hit = 1'b0;
                    ST_EQUAL:
                        if (b == CH_QUOTE)
                        begin
                            nxt = ST_AVALUE; slack = 1'b0;
                        end
                        else
                            hit = 1'b0;
                    ST_AVALUE:
                        if (b == CH_QUOTE)
                        begin
                            nxt = ST_AWAIT; delta = -1;
                        end
                        else
                            hit = 1'b0;
                    ST_NAME:
                        if (b == CH_GT)
                            nxt = ST_BODY;
                        else if (is_sep(b))
                            nxt = ST_AWAIT;
                        else
                            hit = 1'b0;
                    ST_STRING:
                        if (b == CH_LT)
                        begin
                            nxt = ST_LABEL; delta = -1; slack = 1'b0;
                        end
                        else if (is_sep(b))
                        begin
                            nxt = ST_BODY; delta = -1;
                        end
                        else
                            hit = 1'b0;
                    default:
                        hit = 1'b0;
                endcase
                // no table entry: state and blank skipping stay as they are
                if (!hit)
                    slack = tk_skip;
                nd = tk_level + delta;
                if (nd >= MAX_DEPTH)
                    tk_done = STAT_OVERFLOW;
                else if (nd < 0)
                    tk_done = STAT_PAST_ROOT;
                else
                begin
                    r.level_open  = (nd > tk_level);
                    r.level_close = (nd < tk_level);
                    if (is_rec(tk_state) && !is_rec(nxt))
                    begin
                        r.kind    = kind_t'(tk_state[2:0]);
                        r.rec_end = 1'b1;
                    end
                    else if (cross_rec || is_rec(tk_state))
                    begin
                        r.kind       = cross_rec ? kind_t'(nxt[2:0]) : kind_t'(tk_state[2:0]);
                        r.char_valid = 1'b1;
                        r.out_char   = b;
                    end
                    tk_level = nd;
                    tk_state = nxt;
                    tk_skip  = slack;
                end
            end
        end
        r.depth  = tk_level[DEPTH_W-1:0];
        r.status = tk_done;
        return r;
    endfunction

    // ---------------- document builders ----------------

    task automatic push_byte(input logic [7:0] c);
        doc_bytes.push_back('{c, start_next, drain_next});
        start_next = 1'b0;
        drain_next = 1'b0;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return 8'h09;
            1: return 8'h0A;
            2: return 8'h0D;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (c == CH_LT || c == CH_GT || c == CH_SLASH || c == CH_BANG ||
               c == CH_QMARK || c == CH_EQ || c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_QUOTE);
        return c;
    endfunction

    task automatic push_word(input int n);
        repeat (n)
            push_byte(plain_char());
    endtask

    task automatic gen_element(input int lvl, input int max_lvl);
        int n_attr;
        int n_kids;
        push_byte(CH_LT);
        push_word($urandom_range(1, 4));
        n_attr = $urandom_range(0, 2);
        repeat (n_attr)
        begin
            push_byte(blank_char());
            push_word($urandom_range(1, 3));
            push_byte(CH_EQ);
            push_byte(CH_QUOTE);
            repeat ($urandom_range(0, 4))
                push_byte(value_char());
            push_byte(CH_QUOTE);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            // empty element, closed inside its own tag
            push_byte(blank_char());
            push_byte(CH_SLASH);
            push_byte(CH_GT);
        end
        else
        begin
            push_byte(CH_GT);
            n_kids = $urandom_range(0, 3);
            repeat (n_kids)
            begin
                case ($urandom_range(0, 3))
                    0:
                        if (lvl < max_lvl)
                            gen_element(lvl + 1, max_lvl);
                        else
                            push_word($urandom_range(1, 5));
                    1:
                    begin
                        push_word($urandom_range(1, 5));
                        if ($urandom_range(0, 1))
                            push_byte(blank_char());
                    end
                    2:
                    begin
                        push_byte(CH_LT);
                        push_byte($urandom_range(0, 1) ? CH_BANG : CH_QMARK);
                        push_word($urandom_range(0, 3));
                        push_byte(CH_GT);
                    end
                    default:
                        repeat ($urandom_range(1, 3))
                            push_byte(blank_char());
                endcase
            end
            push_byte(CH_LT);
            push_byte(CH_SLASH);
            push_word($urandom_range(1, 3));
            push_byte(CH_GT);
        end
    endtask

    task automatic gen_doc();
        start_next = 1'b1;
        if ($urandom_range(0, 1))
            push_byte(blank_char());
        if ($urandom_range(0, 3) == 0)
            push_str("<?xml version=\"1.0\"?>");
        gen_element(0, $urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
            push_str("</x>");
        if ($urandom_range(0, 1))
            push_byte(CH_NUL);
    endtask

    // nested elements up to and past the depth limit
    task automatic gen_deep(input int n);
        start_next = 1'b1;
        repeat (n)
            push_str("<d>");
        push_word(2);
        if (n <= 30)
            repeat (n)
                push_str("</d>");
        push_byte(CH_NUL);
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            s_tuser    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_tokens.push_back(tokenize_byte(s_tdata, s_tuser));
            if (!s_tvalid || s_tready)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (burst_left == 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (doc_bytes.size() != 0 &&
                         !(doc_bytes[0].drain && expected_tokens.size() != 0))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= doc_bytes[0].ch;
                    s_tuser  <= doc_bytes[0].sod;
                    void'(doc_bytes.pop_front());
                    burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver stalls ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  = 0;
            holds_done = 0;
            rx_tick    = 0;
            rx_mode    = 0;
        end
        else
        begin
            rx_tick++;
            if (rx_tick % 48 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (holds_done < 2 && tokens_seen >= 300 + 400 * holds_done)
            begin
                // long back-pressure so the core fills and drops s_tready
                hold_left = 80;
                holds_done++;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (rx_tick[1:0] == 2'b11);
                endcase
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("token beat with nothing expected");
            end
            else
            begin
                token_want = expected_tokens.pop_front();
                check_field("record_kind", token_want.kind, m_tuser);
                check_field("char_valid", token_want.char_valid, m_tdata[0]);
                check_field("out_char", token_want.out_char, m_tdata[8:1]);
                check_field("record_end", token_want.rec_end, m_tlast);
                check_field("level_open", token_want.level_open, m_tdata[9]);
                check_field("level_close", token_want.level_close, m_tdata[10]);
                check_field("nest_depth", token_want.depth, m_tdata[15:11]);
                check_field("parse_status", token_want.status, m_tdata[17:16]);
                check_field("tdata_pad", 0, m_tdata[TDATA_W-1:18]);
            end
            tokens_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("xml_char_tokenizer_core regression: fail");
            $finish;
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial
    begin
        // directed: skipped blank, every record kind, high bytes in a value,
        // markup, close past root, ignored byte after finish, zero byte
        start_next = 1'b1;
        push_byte(CH_SPACE);
        push_str("<a b=\"");
        push_byte(8'hFF);
        push_byte(8'h80);
        push_str("\">t ");
        push_str("</a><?><!></>x");
        start_next = 1'b1;
        push_byte(CH_NUL);

        // random: overflow first, behind a full drain of the pipeline
        drain_next = 1'b1;
        gen_deep(33);
        while (doc_bytes.size() < DOC_TARGET)
        begin
            if ($urandom_range(0, 11) == 0)
                drain_next = 1'b1;
            case ($urandom_range(0, 19))
                0:
                    gen_deep($urandom_range(29, 32));
                1, 2:
                    repeat ($urandom_range(1, 12))
                    begin
                        start_next = ($urandom_range(0, 15) == 0);
                        push_byte(8'($urandom_range(0, 255)));
                    end
                3, 4:
                begin
                    // broken document: cut short, then one random byte
                    gen_doc();
                    repeat ($urandom_range(1, 6))
                        void'(doc_bytes.pop_back());
                    push_byte(8'($urandom_range(0, 255)));
                end
                default:
                    gen_doc();
            endcase
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (doc_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("xml_char_tokenizer_core regression: pass");
        else
            $display("xml_char_tokenizer_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/xct_pkg.sv
rtl/core/xct_step.sv
rtl/core/xml_char_tokenizer_core.sv
bench/tb_xml_char_tokenizer_core.sv
